[rtl/urm_pkg.sv]
// Shared types and constants for the UART register model.
package urm_pkg;

    // Transaction kinds.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Register offsets.
    localparam logic [3:0] REG_SR   = 4'd0;
    localparam logic [3:0] REG_DR   = 4'd1;
    localparam logic [3:0] REG_BRR1 = 4'd2;
    localparam logic [3:0] REG_BRR2 = 4'd3;
    localparam logic [3:0] REG_CR1  = 4'd4;
    localparam logic [3:0] REG_CR2  = 4'd5;

    // SR flag bits.
    localparam int SR_TXE  = 7;
    localparam int SR_TC   = 6;
    localparam int SR_RXNE = 5;
    localparam int SR_IDLE = 4;
    localparam int SR_OR   = 3;
    localparam logic [7:0] SR_ERR_MASK = 8'h1F;
    localparam logic [7:0] SR_RESET    = 8'hC0;

    // CR1 and CR2 control bits.
    localparam int CR1_DISABLE = 5;
    localparam int CR2_TXE_IE  = 7;
    localparam int CR2_TC_IE   = 6;
    localparam int CR2_RXNE_IE = 5;
    localparam int CR2_TX_EN   = 3;
    localparam int CR2_RX_EN   = 2;

    localparam logic [23:0] PRESCALE_MAX = 24'hFF_FFFF;
    localparam logic [3:0]  BIT_MAX      = 4'd15;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] reg_index;
        logic [7:0] write_value;
        logic [7:0] tick_cycles;
        logic       rx_ready;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_tx_empty;
        logic       irq_tx_complete;
        logic       irq_receive;
    } t_result;

    typedef struct packed {
        logic [7:0]  rx_data_hold;
        logic [7:0]  rx_pending_byte;
        logic [7:0]  tx_hold_byte;
        logic [7:0]  tx_shift_byte;
        logic        tx_hold_full;
        logic        tx_busy;
        logic        rx_busy;
        logic        status_was_read;
        logic [23:0] prescale_count;
        logic [3:0]  tx_bit_count;
        logic [3:0]  rx_bit_count;
    } t_ctrl;

endpackage

[rtl/urm_if.sv]
// Valid/ready channel interfaces for bus transactions and their results.
interface urm_item_if import urm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface urm_result_if import urm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/uart_register_model.sv]
// Top level of the UART register model: input register, state and result register.
//
// UART register model with a fractional baud divider. Each transaction on
// i_req is a bus read, a bus write or a tick of a number of clock cycles;
// each produces exactly one result transaction on o_rsp carrying read data,
// a finished transmit byte (if any) and the three interrupt lines taken after
// the update. The block accepts one transaction per clock while o_rsp is not
// stalled; each transaction passes through the input register, then the
// result register. The rate is set by the combinational state update,
// whose longest path is the 24-bit prescaler add, saturate, compare and
// subtract against the 16-bit divisor built from BRR1 and BRR2. A stalled
// result holds in the result register while the input register keeps one
// more transaction, so o_rsp back-pressure reaches i_req only after both fill.
module uart_register_model import urm_pkg::*; #(
    parameter int FRAME_BITS = 10,
    parameter int NUM_REGS   = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    urm_item_if.sink           i_req,
    urm_result_if.source       o_rsp
);

    // Input stage
    logic    r_in_valid;
    t_item   r_in;

    // Block state
    t_ctrl      r_ctrl;
    t_ctrl      n_ctrl;
    logic [7:0] r_regs [NUM_REGS];
    logic [7:0] n_regs [NUM_REGS];

    // Result stage
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic advance;

    // Move the held transaction forward when the result register is free or drains.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    urm_step #(
        .FRAME_BITS (FRAME_BITS),
        .NUM_REGS   (NUM_REGS)
    ) u_step (
        .i_item   (r_in),
        .i_ctrl   (r_ctrl),
        .i_regs   (r_regs),
        .o_ctrl   (n_ctrl),
        .o_regs   (n_regs),
        .o_result (n_out)
    );

    // Control: stage valids and the UART state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctrl      <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= (i == int'(REG_SR)) ? SR_RESET : 8'h00;
            end
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctrl      <= n_ctrl;
                r_regs      <= n_regs;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the accepted transaction and the computed result.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/urm_step.sv]
// Next-state and result logic for one bus read, bus write or tick.
module urm_step import urm_pkg::*; #(
    parameter int FRAME_BITS = 10,
    parameter int NUM_REGS   = 12
) (
    input  t_item      i_item,
    input  t_ctrl      i_ctrl,
    input  logic [7:0] i_regs [NUM_REGS],
    output t_ctrl      o_ctrl,
    output logic [7:0] o_regs [NUM_REGS],
    output t_result    o_result
);

    localparam int         IDX_W     = $clog2(NUM_REGS);
    localparam logic [4:0] REG_LIMIT = 5'(NUM_REGS);
    localparam logic [3:0] FRAME_CNT = 4'(FRAME_BITS);

    logic [IDX_W-1:0] idx;
    logic             idx_ok;
    logic [15:0]      divisor;
    logic [24:0]      p_sum;
    logic [23:0]      p_sat;
    logic             tx_en;
    logic             rx_en;

    assign idx     = i_item.reg_index[IDX_W-1:0];
    assign idx_ok  = {1'b0, i_item.reg_index} < REG_LIMIT;
    assign divisor = {i_regs[REG_BRR2][7:4], i_regs[REG_BRR1], i_regs[REG_BRR2][3:0]};
    assign p_sum   = {1'b0, i_ctrl.prescale_count} + 25'(i_item.tick_cycles);
    assign p_sat   = p_sum[24] ? PRESCALE_MAX : p_sum[23:0];
    assign tx_en   = i_regs[REG_CR2][CR2_TX_EN];
    assign rx_en   = i_regs[REG_CR2][CR2_RX_EN];

    always_comb begin
        o_ctrl   = i_ctrl;
        o_regs   = i_regs;
        o_result = '0;

        case (i_item.kind)
            KIND_READ: begin
                if (i_item.reg_index == REG_DR) begin
                    if (i_ctrl.status_was_read) begin
                        o_regs[REG_SR] = o_regs[REG_SR] & ~SR_ERR_MASK;
                    end
                    o_regs[REG_SR][SR_RXNE] = 1'b0;
                    o_result.read_data      = i_ctrl.rx_data_hold;
                end else begin
                    o_ctrl.status_was_read = (i_item.reg_index == REG_SR);
                    if (idx_ok) begin
                        o_result.read_data = i_regs[idx];
                    end
                end
            end
            KIND_WRITE: begin
                if (idx_ok) begin
                    if (i_item.reg_index == REG_SR) begin
                        // TC can only be cleared, by writing zero to it
                        if (!i_item.write_value[SR_TC]) begin
                            o_regs[REG_SR][SR_TC] = 1'b0;
                        end
                    end else begin
                        o_regs[idx] = i_item.write_value;
                        case (i_item.reg_index)
                            REG_BRR1, REG_BRR2: begin
                                o_ctrl.prescale_count = '0;
                            end
                            REG_CR1, REG_CR2: begin
                                o_ctrl.tx_bit_count = '0;
                                o_ctrl.rx_bit_count = '0;
                                o_ctrl.rx_busy      = 1'b0;
                                o_ctrl.tx_hold_full = 1'b0;
                            end
                            REG_DR: begin
                                o_ctrl.tx_hold_byte    = i_item.write_value;
                                o_ctrl.tx_hold_full    = 1'b1;
                                o_regs[REG_SR][SR_TXE] = 1'b0;
                                if (i_ctrl.status_was_read) begin
                                    o_regs[REG_SR][SR_TC] = 1'b0;
                                end
                                if (!i_ctrl.tx_busy && tx_en) begin
                                    o_ctrl.tx_shift_byte   = i_item.write_value;
                                    o_ctrl.tx_hold_full    = 1'b0;
                                    o_ctrl.tx_busy         = 1'b1;
                                    o_ctrl.tx_bit_count    = '0;
                                    o_regs[REG_SR][SR_TXE] = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                o_ctrl.status_was_read = 1'b0;
            end
            KIND_TICK: begin
                if (!i_regs[REG_CR1][CR1_DISABLE]) begin
                    if (p_sat < 24'(divisor)) begin
                        o_ctrl.prescale_count = p_sat;
                    end else begin
                        o_ctrl.prescale_count = p_sat - 24'(divisor);
                        if (tx_en && o_ctrl.tx_bit_count < BIT_MAX) begin
                            o_ctrl.tx_bit_count = o_ctrl.tx_bit_count + 4'd1;
                        end
                        if (rx_en && o_ctrl.rx_bit_count < BIT_MAX) begin
                            o_ctrl.rx_bit_count = o_ctrl.rx_bit_count + 4'd1;
                        end

                        // finish the transmit frame, then load the next held byte
                        if (o_ctrl.tx_busy && o_ctrl.tx_bit_count >= FRAME_CNT) begin
                            o_ctrl.tx_busy      = 1'b0;
                            o_result.tx_valid   = 1'b1;
                            o_result.tx_byte    = o_ctrl.tx_shift_byte;
                            o_ctrl.tx_bit_count = o_ctrl.tx_bit_count - FRAME_CNT;
                            if (o_ctrl.tx_hold_full) begin
                                if (tx_en) begin
                                    o_ctrl.tx_shift_byte   = o_ctrl.tx_hold_byte;
                                    o_ctrl.tx_hold_full    = 1'b0;
                                    o_ctrl.tx_busy         = 1'b1;
                                    o_ctrl.tx_bit_count    = '0;
                                    o_regs[REG_SR][SR_TXE] = 1'b1;
                                end
                            end else begin
                                o_regs[REG_SR][SR_TXE] = 1'b1;
                                o_regs[REG_SR][SR_TC]  = 1'b1;
                            end
                        end

                        // start reception or flag an idle line
                        if (rx_en && !o_ctrl.rx_busy) begin
                            if (i_item.rx_ready) begin
                                o_ctrl.rx_busy         = 1'b1;
                                o_ctrl.rx_bit_count    = '0;
                                o_ctrl.rx_pending_byte = i_item.rx_byte;
                            end else begin
                                o_regs[REG_SR][SR_IDLE] = 1'b1;
                            end
                        end

                        if (o_ctrl.rx_busy && o_ctrl.rx_bit_count >= FRAME_CNT) begin
                            o_ctrl.rx_data_hold = o_ctrl.rx_pending_byte;
                            o_regs[REG_DR]      = o_ctrl.rx_pending_byte;
                            if (o_regs[REG_SR][SR_RXNE]) begin
                                o_regs[REG_SR][SR_OR] = 1'b1;
                            end
                            o_regs[REG_SR][SR_RXNE] = 1'b1;
                            o_ctrl.rx_busy          = 1'b0;
                            o_ctrl.rx_bit_count     = o_ctrl.rx_bit_count - FRAME_CNT;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.irq_tx_empty    = o_regs[REG_CR2][CR2_TXE_IE] & o_regs[REG_SR][SR_TXE];
        o_result.irq_tx_complete = o_regs[REG_CR2][CR2_TC_IE] & o_regs[REG_SR][SR_TC];
        o_result.irq_receive     = o_regs[REG_CR2][CR2_RXNE_IE] & o_regs[REG_SR][SR_RXNE];
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for uart_register_model: directed and random bus traffic against a shadow UART.
module tb;
    import urm_pkg::*;

    localparam int FRAME_BITS   = 10;
    localparam int NUM_REGS     = 12;
    localparam int ITEM_GOAL    = 1200;
    localparam int CALM_ITEMS   = 150;    // tail of the run with no idling on either side
    localparam int DRAIN_CYCLES = 8;      // two-stage pipe, plus margin
    localparam int CYCLE_LIMIT  = 200000;

    // Kind code the block does not define; it must leave the state alone.
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    // Shadow of the UART: predicts the response to every accepted transaction
    // and holds the predictions until the block returns them.
    class uart_response_board;
        logic [7:0]  regs [NUM_REGS];
        logic [7:0]  rx_latched;
        logic [7:0]  rx_incoming;
        logic [7:0]  tx_holding;
        logic [7:0]  tx_shifting;
        logic        holding_full;
        logic        sending;
        logic        receiving;
        logic        sr_just_read;
        logic [23:0] prescaler;
        logic [3:0]  tx_bits;
        logic [3:0]  rx_bits;
        t_result     expected_responses [$];
        int          mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[REG_SR] = SR_RESET;
            rx_latched   = '0;
            rx_incoming  = '0;
            tx_holding   = '0;
            tx_shifting  = '0;
            holding_full = 1'b0;
            sending      = 1'b0;
            receiving    = 1'b0;
            sr_just_read = 1'b0;
            prescaler    = '0;
            tx_bits      = '0;
            rx_bits      = '0;
            mismatches   = 0;
        endfunction

        // Move the held byte into the shifter, if the transmitter is on.
        function void load_shifter();
            if (regs[REG_CR2][CR2_TX_EN]) begin
                tx_shifting          = tx_holding;
                holding_full         = 1'b0;
                sending              = 1'b1;
                tx_bits              = '0;
                regs[REG_SR][SR_TXE] = 1'b1;
            end
        endfunction

        function void note_transaction(t_item it);
            t_result     r;
            logic [24:0] sum;
            logic [15:0] div;
            r = '0;
            case (it.kind)
                KIND_READ: begin
                    if (it.reg_index == REG_DR) begin
                        // Status then data read clears the error flags; the
                        // status-read marker itself survives a data read.
                        if (sr_just_read) regs[REG_SR] &= ~SR_ERR_MASK;
                        regs[REG_SR][SR_RXNE] = 1'b0;
                        r.read_data = rx_latched;
                    end else begin
                        sr_just_read = (it.reg_index == REG_SR);
                        if (it.reg_index < NUM_REGS) r.read_data = regs[it.reg_index];
                    end
                end
                KIND_WRITE: begin
                    if (it.reg_index == REG_SR) begin
                        // Only TC is writable, and only toward zero.
                        if (!it.write_value[SR_TC]) regs[REG_SR][SR_TC] = 1'b0;
                    end else if (it.reg_index < NUM_REGS) begin
                        regs[it.reg_index] = it.write_value;
                        case (it.reg_index)
                            REG_BRR1, REG_BRR2: prescaler = '0;
                            REG_CR1, REG_CR2: begin
                                tx_bits      = '0;
                                rx_bits      = '0;
                                receiving    = 1'b0;
                                holding_full = 1'b0;
                            end
                            REG_DR: begin
                                tx_holding           = it.write_value;
                                holding_full         = 1'b1;
                                regs[REG_SR][SR_TXE] = 1'b0;
                                if (sr_just_read) regs[REG_SR][SR_TC] = 1'b0;
                                if (!sending) load_shifter();
                            end
                            default: ;
                        endcase
                    end
                    sr_just_read = 1'b0;
                end
                KIND_TICK: begin
                    if (!regs[REG_CR1][CR1_DISABLE]) begin
                        div = {regs[REG_BRR2][7:4], regs[REG_BRR1], regs[REG_BRR2][3:0]};
                        sum = {1'b0, prescaler} + 25'(it.tick_cycles);
                        if (sum > {1'b0, PRESCALE_MAX}) sum = {1'b0, PRESCALE_MAX};
                        if (sum < 25'(div)) begin
                            prescaler = sum[23:0];
                        end else begin
                            // At most one bit time per tick.
                            prescaler = sum[23:0] - 24'(div);
                            if (regs[REG_CR2][CR2_TX_EN] && tx_bits < BIT_MAX) tx_bits++;
                            if (regs[REG_CR2][CR2_RX_EN] && rx_bits < BIT_MAX) rx_bits++;
                            if (sending && tx_bits >= FRAME_BITS) begin
                                sending    = 1'b0;
                                r.tx_valid = 1'b1;
                                r.tx_byte  = tx_shifting;
                                tx_bits    = tx_bits - 4'(FRAME_BITS);
                                if (holding_full) begin
                                    load_shifter();
                                end else begin
                                    regs[REG_SR][SR_TXE] = 1'b1;
                                    regs[REG_SR][SR_TC]  = 1'b1;
                                end
                            end
                            if (regs[REG_CR2][CR2_RX_EN] && !receiving) begin
                                if (it.rx_ready) begin
                                    receiving   = 1'b1;
                                    rx_bits     = '0;
                                    rx_incoming = it.rx_byte;
                                end else begin
                                    regs[REG_SR][SR_IDLE] = 1'b1;
                                end
                            end
                            if (receiving && rx_bits >= FRAME_BITS) begin
                                rx_latched   = rx_incoming;
                                regs[REG_DR] = rx_incoming;
                                if (regs[REG_SR][SR_RXNE]) regs[REG_SR][SR_OR] = 1'b1;
                                regs[REG_SR][SR_RXNE] = 1'b1;
                                receiving = 1'b0;
                                rx_bits   = rx_bits - 4'(FRAME_BITS);
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.irq_tx_empty    = regs[REG_CR2][CR2_TXE_IE]  & regs[REG_SR][SR_TXE];
            r.irq_tx_complete = regs[REG_CR2][CR2_TC_IE]   & regs[REG_SR][SR_TC];
            r.irq_receive     = regs[REG_CR2][CR2_RXNE_IE] & regs[REG_SR][SR_RXNE];
            expected_responses.push_back(r);
        endfunction

        function void check_response(t_result got);
            t_result want;
            if (expected_responses.size() == 0) begin
                $error("response with nothing outstanding: %h", got);
                mismatches++;
                return;
            end
            want = expected_responses.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
                mismatches++;
            end
            if (got.tx_valid !== want.tx_valid) begin
                $error("tx_valid: expected %0h, got %0h", want.tx_valid, got.tx_valid);
                mismatches++;
            end
            if (got.tx_byte !== want.tx_byte) begin
                $error("tx_byte: expected %0h, got %0h", want.tx_byte, got.tx_byte);
                mismatches++;
            end
            if (got.irq_tx_empty !== want.irq_tx_empty) begin
                $error("irq_tx_empty: expected %0h, got %0h",
                       want.irq_tx_empty, got.irq_tx_empty);
                mismatches++;
            end
            if (got.irq_tx_complete !== want.irq_tx_complete) begin
                $error("irq_tx_complete: expected %0h, got %0h",
                       want.irq_tx_complete, got.irq_tx_complete);
                mismatches++;
            end
            if (got.irq_receive !== want.irq_receive) begin
                $error("irq_receive: expected %0h, got %0h",
                       want.irq_receive, got.irq_receive);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    urm_item_if   req_if ();
    urm_result_if rsp_if ();

    uart_register_model #(
        .FRAME_BITS (FRAME_BITS),
        .NUM_REGS   (NUM_REGS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    uart_response_board board;
    bit                 calm;
    int                 sender_idle_pct;
    int                 cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either channel.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Sample both channels at the rising edge; values were set up at the
    // preceding falling edge, so ordering inside the time step does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) board.note_transaction(req_if.data);
            if (rsp_if.valid && rsp_if.ready) board.check_response(rsp_if.data);
        end
    end

    // Response back-pressure: short stall bursts, long clean stretches, and
    // nothing at all once the run turns calm.
    initial begin
        int pick;
        rsp_if.ready = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            pick = $urandom_range(0, 99);
            if (!calm && pick < 20) begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                rsp_if.ready = 1'b1;
            end else if (pick < 25) begin
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    end

    function automatic t_item make_access(logic [1:0] kind, logic [3:0] idx, logic [7:0] value);
        t_item it;
        // Fill the fields the kind ignores with noise too.
        it.kind        = kind;
        it.reg_index   = idx;
        it.write_value = value;
        it.tick_cycles = 8'($urandom_range(0, 255));
        it.rx_ready    = 1'($urandom_range(0, 1));
        it.rx_byte     = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_item make_tick(logic [7:0] cycles, logic rdy, logic [7:0] rx_value);
        t_item it;
        it             = make_access(KIND_TICK, 4'($urandom_range(0, 15)),
                                     8'($urandom_range(0, 255)));
        it.tick_cycles = cycles;
        it.rx_ready    = rdy;
        it.rx_byte     = rx_value;
        return it;
    endfunction

    // Present one transaction at a falling edge and hold it until accepted.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_transaction(input t_item it);
        if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = it;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_item      it;
        logic [7:0] v;
        int         pick;
        int         sent;
        int         next_shuffle;

        board           = new();
        calm            = 1'b0;
        sender_idle_pct = 30;
        cycle_count     = 0;
        req_if.valid    = 1'b0;
        req_if.data     = '0;
        i_rst_n         = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset values, status-then-data clear, out-of-range access,
        // the undefined kind, a back-to-back send with zero divisor, a full
        // receive, disabled ticks and the widest divisor.
        send_transaction(make_access(KIND_READ, REG_SR, 8'h00));
        send_transaction(make_access(KIND_READ, REG_DR, 8'h00));
        send_transaction(make_access(KIND_READ, 4'd15, 8'h00));
        send_transaction(make_access(KIND_WRITE, 4'd12, 8'hFF));
        send_transaction('1);
        send_transaction(make_access(KIND_WRITE, REG_CR2, 8'hEC));
        send_transaction(make_access(KIND_WRITE, REG_DR, 8'hA5));
        send_transaction(make_access(KIND_WRITE, REG_DR, 8'hFF));
        for (int k = 0; k < 11; k++)
            send_transaction(make_tick(k[0] ? 8'hFF : 8'h00, 1'b1, k[0] ? 8'hFF : 8'h00));
        send_transaction(make_access(KIND_READ, REG_SR, 8'h00));
        send_transaction(make_access(KIND_READ, REG_DR, 8'h00));
        send_transaction(make_access(KIND_WRITE, REG_SR, 8'h00));
        send_transaction(make_access(KIND_WRITE, REG_CR1, 8'h20));
        send_transaction(make_tick(8'hFF, 1'b1, 8'h5A));
        send_transaction(make_access(KIND_WRITE, REG_CR1, 8'h00));
        send_transaction(make_access(KIND_WRITE, REG_BRR1, 8'hFF));
        send_transaction(make_access(KIND_WRITE, REG_BRR2, 8'hFF));
        send_transaction(make_tick(8'hFF, 1'b0, 8'h00));

        // Random: bring the divisor back down so frames finish, then mostly
        // ticks and data traffic with the occasional control write or noise.
        send_transaction(make_access(KIND_WRITE, REG_BRR1, 8'h00));
        send_transaction(make_access(KIND_WRITE, REG_BRR2, 8'h03));
        sent         = 0;
        next_shuffle = 0;
        while (sent < ITEM_GOAL) begin
            if (sent >= next_shuffle) begin
                sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
                next_shuffle += 64;
            end
            calm = (sent >= ITEM_GOAL - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                send_transaction(make_tick(8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1)),
                                           8'($urandom_range(0, 255))));
            end else if (pick < 56) begin
                send_transaction(make_access(KIND_WRITE, REG_DR, 8'($urandom_range(0, 255))));
            end else if (pick < 66) begin
                // Proper clear sequence for the error flags.
                send_transaction(make_access(KIND_READ, REG_SR, 8'h00));
                send_transaction(make_access(KIND_READ, REG_DR, 8'h00));
                sent++;
            end else if (pick < 70) begin
                // Status read followed by a data write clears TC.
                send_transaction(make_access(KIND_READ, REG_SR, 8'h00));
                send_transaction(make_access(KIND_WRITE, REG_DR, 8'($urandom_range(0, 255))));
                sent++;
            end else if (pick < 76) begin
                send_transaction(make_access(KIND_READ, 4'($urandom_range(0, 15)), 8'h00));
            end else if (pick < 80) begin
                send_transaction(make_access(KIND_WRITE, REG_SR, 8'($urandom_range(0, 255))));
            end else if (pick < 83) begin
                v = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0) begin
                    v[CR2_TX_EN] = 1'b1;
                    v[CR2_RX_EN] = 1'b1;
                end
                send_transaction(make_access(KIND_WRITE, REG_CR2, v));
            end else if (pick < 85) begin
                v = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 4) != 0) v[CR1_DISABLE] = 1'b0;
                send_transaction(make_access(KIND_WRITE, REG_CR1, v));
            end else if (pick < 89) begin
                // Keep the divisor small most of the time.
                v = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3));
                send_transaction(make_access(KIND_WRITE,
                                             $urandom_range(0, 1) ? REG_BRR1 : REG_BRR2, v));
            end else if (pick < 93) begin
                send_transaction(make_access(KIND_WRITE, 4'($urandom_range(6, 15)),
                                             8'($urandom_range(0, 255))));
            end else if (pick < 96) begin
                send_transaction(make_access(KIND_UNDEF, 4'($urandom_range(0, 15)),
                                             8'($urandom_range(0, 255))));
            end else begin
                send_transaction(make_access(2'($urandom_range(0, 3)),
                                             4'($urandom_range(0, 15)),
                                             8'($urandom_range(0, 255))));
            end
            sent++;
        end
        req_if.valid = 1'b0;

        // Drain: wait for every response, then a few cycles for strays.
        while (board.expected_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_responses.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
